FILE: hw/rtl/text_console_writer_assert.svh
// ---------------------------------------------------------------------------
// text_console_writer_assert.svh
// assertion macros for the text console writer; empty for synthesis
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define TCW_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tcw assertion failed");

// consequence holds in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`else

`define TCW_ASSERT(label, cond)
`define TCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// shared types and codes of the text console writer
// ---------------------------------------------------------------------------
package tcw_pkg;

  // widest cell address over the supported geometry (64 rows x 128 columns)
  localparam int ADDR_MAX_W = 13;
  localparam int CFG_IDX_W  = 4;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 4'd1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h0f;
  localparam logic [3:0] RESET_FG     = 4'd15;
  localparam logic [3:0] RESET_BG     = 4'd0;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] code;
  } cell_t;

  localparam cell_t RESET_CELL = '{attr: RESET_ATTR, code: BLANK_CODE};

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ADDR_MAX_W-1:0] addr;
    cell_t                 wdata;
  } mem_req_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } result_t;

endpackage

FILE: hw/rtl/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// text console engine over a ROWS x COLUMNS store of character cells
// ---------------------------------------------------------------------------
// steps: EXEC then DONE for a command, EXEC, RDWAIT, DONE for an in-range read;
//   a put that scrolls adds a COLUMNS-cell sweep, clear a ROWS*COLUMNS-cell sweep
// one item at a time: the next is taken once the last result is handed over;
//   the single-port cell memory sets the fill and scroll sweeps, one cell a cycle
// reset: cursor, base row and colors return to defaults, then a sweep over all
//   ROWS*COLUMNS cells writes blank cells while in_ready stays low
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]           cfg_data,
  // command channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [7:0]           char_code,
  input  logic [4:0]           read_row,
  input  logic [6:0]           read_col,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           cursor_row,
  output logic [6:0]           cursor_col,
  output logic [7:0]           cell_char,
  output logic [7:0]           cell_attr
);

  // color registers; attribute has background in the high nibble
  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic [7:0] attr;

  // engine to cell memory
  mem_req_t mem_req;
  cell_t    mem_rdata;

  // engine result handoff into the output register
  logic    res_valid;
  logic    res_ready;
  result_t res;
  item_t   item;

  assign cfg_ready = 1'b1;
  assign attr      = {bg_color, fg_color};
  assign item      = '{command: command, char_code: char_code,
                       read_row: read_row, read_col: read_col};

  // writes to an index past the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= RESET_FG;
      bg_color <= RESET_BG;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FG_COLOR) begin
        fg_color <= cfg_data;
      end else if (cfg_index == REG_BG_COLOR) begin
        bg_color <= cfg_data;
      end
    end
  end

  tcw_cell_mem #(
    .DEPTH (ROWS * COLUMNS)
  ) u_cell_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (item),
    .attr       (attr),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register: the engine hands over a result when the slot is free or
  // being emptied this cycle, so a waiting result does not stall new commands
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cursor_row <= res.cursor_row;
      cursor_col <= res.cursor_col;
      cell_char  <= res.cell_char;
      cell_attr  <= res.cell_attr;
    end
  end

endmodule

FILE: hw/rtl/tcw_cell_mem.sv
// ---------------------------------------------------------------------------
// tcw_cell_mem
// single-port cell store, one write or one registered read per cycle
// ---------------------------------------------------------------------------
module tcw_cell_mem import tcw_pkg::*; #(
  parameter int DEPTH = 2000
) (
  input  logic     clk,
  input  mem_req_t req,
  output cell_t    rdata
);

  localparam int AW = $clog2(DEPTH);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

FILE: hw/rtl/tcw_engine.sv
// ---------------------------------------------------------------------------
// tcw_engine
// command sequencer: cursor, rotating base row and fill sweeps
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_engine import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  item_t    item,
  input  logic [7:0] attr,
  output mem_req_t mem_req,
  input  cell_t    mem_rdata,
  output logic     res_valid,
  input  logic     res_ready,
  output result_t  res
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]       state;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] base;
  logic [AW-1:0]    sweep;
  logic [AW-1:0]    sweep_last;
  cell_t            sweep_fill;
  logic             sweep_boot;
  item_t            it;
  logic [7:0]       res_char;
  logic [7:0]       res_attr;

  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    base_addr;
  logic             rd_in_range;
  logic             is_newline;
  logic             wrap;
  logic             last_row;
  cell_t            blank;

  // logical row to physical row through the rotating base
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  assign blank       = '{attr: attr, code: BLANK_CODE};
  assign cur_addr    = AW'(phys_row(cur_row, base) * COLUMNS) + AW'(cur_col);
  assign rd_addr     = AW'(phys_row(ROW_W'(it.read_row), base) * COLUMNS)
                     + AW'(it.read_col);
  assign base_addr   = AW'(base * COLUMNS);
  assign rd_in_range = (32'(it.read_row) < ROWS) && (32'(it.read_col) < COLUMNS);
  assign is_newline  = (it.char_code == NEWLINE_CODE);
  assign wrap        = is_newline || (cur_col == COL_W'(COLUMNS - 1));
  assign last_row    = (cur_row == ROW_W'(ROWS - 1));

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res        = '{cursor_row: 5'(cur_row), cursor_col: 7'(cur_col),
                        cell_char: res_char, cell_attr: res_attr};

  always_comb begin
    mem_req = '0;
    case (state)
      S_SWEEP: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_MAX_W'(sweep);
        mem_req.wdata = sweep_fill;
      end
      S_EXEC: begin
        if (it.command == CMD_PUT && !is_newline) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = ADDR_MAX_W'(cur_addr);
          mem_req.wdata = '{attr: attr, code: it.char_code};
        end else if (it.command == CMD_READ && rd_in_range) begin
          mem_req.re   = 1'b1;
          mem_req.addr = ADDR_MAX_W'(rd_addr);
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep      <= '0;
      sweep_last <= AW'(DEPTH - 1);
      sweep_fill <= RESET_CELL;
      sweep_boot <= 1'b1;
      cur_row    <= '0;
      cur_col    <= '0;
      base       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            it       <= item;
            res_char <= '0;
            res_attr <= '0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (it.command)
            CMD_PUT: begin
              if (wrap) begin
                cur_col <= '0;
                if (!last_row) begin
                  cur_row <= cur_row + 1'b1;
                  state   <= S_DONE;
                end else begin
                  // old top row becomes the new bottom row, blank it
                  base       <= (base == ROW_W'(ROWS - 1)) ? '0 : base + 1'b1;
                  sweep      <= base_addr;
                  sweep_last <= base_addr + AW'(COLUMNS - 1);
                  sweep_fill <= blank;
                  state      <= S_SWEEP;
                end
              end else begin
                cur_col <= cur_col + 1'b1;
                state   <= S_DONE;
              end
            end
            CMD_CLEAR: begin
              sweep      <= '0;
              sweep_last <= AW'(DEPTH - 1);
              sweep_fill <= blank;
              state      <= S_SWEEP;
            end
            CMD_READ: begin
              state <= rd_in_range ? S_RDWAIT : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RDWAIT: begin
          res_char <= mem_rdata.code;
          res_attr <= mem_rdata.attr;
          state    <= S_DONE;
        end
        S_SWEEP: begin
          if (sweep == sweep_last) begin
            sweep_boot <= 1'b0;
            state      <= sweep_boot ? S_IDLE : S_DONE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCW_ASSERT(a_base_range, 32'(base) < ROWS)
  `TCW_ASSERT(a_cursor_range, (32'(cur_row) < ROWS) && (32'(cur_col) < COLUMNS))
  `TCW_ASSERT(a_sweep_bound, (state != S_SWEEP) || (sweep <= sweep_last))
  `TCW_ASSERT_NEXT(a_read_then_wait, mem_req.re, state == S_RDWAIT)

endmodule

FILE: tb/tb_text_console_writer.sv
// ---------------------------------------------------------------------------
// tb_text_console_writer
// self-checking bench for the text console: a local copy of the cell store,
// cursor and colors predicts every reply, which is checked field by field
// ---------------------------------------------------------------------------
module tb_text_console_writer import tcw_pkg::*;;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  // command value with no meaning: the block only echoes the cursor
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RESET_CYCLES  = 12;
  // a clear result arrives only after its sweep
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  // clear and the reset sweep each run over all ROWS*COLUMNS cells with no transfer
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int MAX_PRINTS    = 100;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_e;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [3:0]           cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [1:0]           command    = CMD_PUT;
  logic [7:0]           char_code  = '0;
  logic [4:0]           read_row   = '0;
  logic [6:0]           read_col   = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [4:0]           cursor_row;
  logic [6:0]           cursor_col;
  logic [7:0]           cell_char;
  logic [7:0]           cell_attr;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .cell_char (cell_char),
    .cell_attr (cell_attr)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // local copy of the console state
  // ------------------------------------------------------------------------
  cell_t      screen_copy [ROWS][COLUMNS];
  logic [4:0] row_now;
  logic [6:0] col_now;
  logic [3:0] fg_now;
  logic [3:0] bg_now;

  // replies predicted at input transfer, oldest first
  result_t replies_due [$];

  int error_count  = 0;
  int items_sent   = 0;
  int stall_cycles = 0;

  // sender pacing and receiver hold-off request
  bit sender_gaps  = 1'b1;
  int burst_left   = 0;
  bit hold_pending = 1'b0;

  function automatic cell_t blank_cell();
    return '{attr: {bg_now, fg_now}, code: BLANK_CODE};
  endfunction

  function automatic void console_reset();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++)
        screen_copy[r][c] = RESET_CELL;
    row_now = '0;
    col_now = '0;
    fg_now  = RESET_FG;
    bg_now  = RESET_BG;
  endfunction

  // newline: next row, or scroll everything up one row on the bottom row
  function automatic void line_feed();
    col_now = '0;
    if (row_now < ROWS - 1) begin
      row_now = row_now + 5'd1;
    end else begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLUMNS; c++)
          screen_copy[r][c] = screen_copy[r+1][c];
      for (int c = 0; c < COLUMNS; c++)
        screen_copy[ROWS-1][c] = blank_cell();
    end
  endfunction

  // applies one command to the local copy and returns the reply it yields
  function automatic result_t apply_command(item_t it);
    result_t rep;
    rep = '0;
    case (it.command)
      CMD_PUT: begin
        if (it.char_code == NEWLINE_CODE) begin
          line_feed();
        end else begin
          screen_copy[row_now][col_now] = '{attr: {bg_now, fg_now}, code: it.char_code};
          col_now = col_now + 7'd1;
          // wrap once the column reaches the line width
          if (col_now >= COLUMNS)
            line_feed();
        end
      end
      CMD_CLEAR: begin
        for (int r = 0; r < ROWS; r++)
          for (int c = 0; c < COLUMNS; c++)
            screen_copy[r][c] = blank_cell();
      end
      CMD_READ: begin
        // out-of-range reads return zero cell bytes
        if (it.read_row < ROWS && it.read_col < COLUMNS) begin
          rep.cell_char = screen_copy[it.read_row][it.read_col].code;
          rep.cell_attr = screen_copy[it.read_row][it.read_col].attr;
        end
      end
      default: ;
    endcase
    rep.cursor_row = row_now;
    rep.cursor_col = col_now;
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH t=%0t reply %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // ------------------------------------------------------------------------
  // monitors: all sampled at the rising edge, before the block's own updates
  // ------------------------------------------------------------------------

  // input transfer advances the local copy and queues the reply
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready === 1'b1)
      replies_due.push_back(apply_command({command, char_code, read_row, read_col}));
  end

  // register write transfer; indexes past the list are dropped
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready === 1'b1) begin
      case (cfg_index)
        REG_FG_COLOR: fg_now = cfg_data;
        REG_BG_COLOR: bg_now = cfg_data;
        default: ;
      endcase
    end
  end

  // result transfer is checked against the oldest predicted reply
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("with none outstanding", 1, 0);
      end else begin
        want = replies_due.pop_front();
        if (cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", cursor_row, want.cursor_row);
        if (cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", cursor_col, want.cursor_col);
        if (cell_char !== want.cell_char)
          report_mismatch("cell_char", cell_char, want.cell_char);
        if (cell_attr !== want.cell_attr)
          report_mismatch("cell_attr", cell_attr, want.cell_attr);
      end
    end
  end

  // watchdog: ends the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_text_console_writer: errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // receiver: stall pattern changes every stretch; long hold on request
  // ------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_e mode;
    int       stretch;
    int       tick;
    mode    = RX_ALWAYS;
    stretch = 0;
    tick    = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_pending) begin
        // hold off long enough for the block to fill and stall its input
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stretch == 0) begin
        mode    = rx_mode_e'($urandom_range(RX_BURSTY, RX_ALWAYS));
        stretch = $urandom_range(256, 32);
      end
      stretch--;
      case (mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(3, 0) != 0);
        RX_SPARSE: out_ready <= (tick % 5 == 0);
        default:   out_ready <= ((tick / 8) % 2 == 0);
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // one input transfer; with sender_gaps set, bursts of random length separated by random gaps
  task automatic send_item(input item_t it);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = $urandom_range(12, 1);
    end
    if (burst_left != 0)
      burst_left--;
    in_valid  <= 1'b1;
    command   <= it.command;
    char_code <= it.char_code;
    read_row  <= it.read_row;
    read_col  <= it.read_col;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  // don't-care fields get random values so every input bit toggles
  task automatic put_char(input logic [7:0] ch);
    send_item({CMD_PUT, ch, 5'($urandom), 7'($urandom)});
  endtask

  task automatic read_cell(input logic [4:0] r, input logic [6:0] c);
    send_item({CMD_READ, 8'($urandom), r, c});
  endtask

  task automatic clear_screen();
    send_item({CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)});
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(255, 0));
    if (ch == NEWLINE_CODE)
      ch = BLANK_CODE;
    return ch;
  endfunction

  // stops offering items until every predicted reply has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_transfer(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // only called with the block idle; ends with a write to an unused index
  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
    reg_transfer(REG_FG_COLOR, fg);
    reg_transfer(REG_BG_COLOR, bg);
    reg_transfer(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_BG_COLOR + 1)),
                 4'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // cells after reset, out-of-range reads and the unused command
  task automatic test_reset_contents();
    read_cell(5'd0, 7'd0);
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd0, 7'(COLUMNS));
    read_cell('1, '1);
    send_item({CMD_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom)});
  endtask

  // extreme character codes, newline, and reading them back
  task automatic test_put_extremes();
    put_char(8'h00);
    put_char(8'hff);
    put_char(8'h41);
    put_char(NEWLINE_CODE);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd2);
  endtask

  // attribute comes from the color registers for written and blanked cells
  task automatic test_color_regs();
    drain_replies();
    set_colors(4'h0, 4'hf);
    put_char(8'h55);
    read_cell(5'd1, 7'd0);
    clear_screen();
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_cell(5'd0, 7'd0);
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_receiver_hold();
    hold_pending = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2)
        read_cell(row_now, 7'($urandom_range(COLUMNS - 1, 0)));
      else
        put_char(text_char());
    end
    drain_replies();
  endtask

  // mostly well-formed text: lines, wraps, scrolls, read-backs, some noise
  task automatic test_random_traffic();
    int target;
    int len;
    int pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_replies();
      case (ph)
        0:       set_colors(4'h0, 4'h0);
        1:       set_colors(4'hf, 4'hf);
        2:       set_colors(4'h0, 4'hf);
        3:       set_colors(4'hf, 4'h0);
        default: set_colors(4'($urandom), 4'($urandom));
      endcase
      sender_gaps = ($urandom_range(3, 0) != 0);
      burst_left  = 0;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
          // text line; some long enough to wrap, up to three times
          len = ($urandom_range(4, 0) == 0) ? $urandom_range(170, COLUMNS - 2)
                                            : $urandom_range(40, 0);
          for (int i = 0; i < len; i++)
            put_char(text_char());
          if ($urandom_range(9, 0) < 7)
            put_char(NEWLINE_CODE);
        end else if (pick < 78) begin
          // read back, mostly around the cursor row
          len = $urandom_range(8, 1);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(1, 0) == 0)
              read_cell(row_now, 7'($urandom_range(COLUMNS - 1, 0)));
            else
              read_cell(5'($urandom_range(ROWS - 1, 0)), 7'($urandom_range(COLUMNS - 1, 0)));
          end
        end else if (pick < 88) begin
          // runs of newlines reach the bottom row and scroll
          len = $urandom_range(30, 1);
          for (int i = 0; i < len; i++)
            put_char(NEWLINE_CODE);
        end else if (pick < 93) begin
          read_cell(5'($urandom_range(31, ROWS)), 7'($urandom));
        end else if (pick < 95) begin
          read_cell(5'($urandom), 7'($urandom_range(127, COLUMNS)));
        end else if (pick < 97) begin
          send_item({CMD_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom)});
        end else if (pick < 98) begin
          clear_screen();
        end else begin
          // sender pause until every reply is back
          drain_replies();
        end
      end
      if (ph == RANDOM_PHASES / 2)
        test_receiver_hold();
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    console_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_contents();
    test_put_extremes();
    test_color_regs();
    test_receiver_hold();
    test_random_traffic();
    drain_replies();
    if (error_count == 0)
      $display("tb_text_console_writer: clean");
    else
      $display("tb_text_console_writer: errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cell_mem.sv
hw/rtl/tcw_engine.sv
hw/rtl/text_console_writer.sv
tb/tb_text_console_writer.sv
